// File: src/lcpd_pkg.sv
// Package for the Lehmer code permutation decoder.
// Field widths, reset constants, the select result struct and the size clamp.
// No dependencies.
package lcpd_pkg;

    localparam int DIGIT_W      = 6;
    localparam int VALUE_W      = 7;
    localparam int SIZE_W       = 7;
    localparam int MAX_SIZE_DEF = 64;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    // Outcome of one select step
    typedef struct packed {
        logic               error;
        logic               last;
        logic [VALUE_W-1:0] value;
    } t_sel;

    // A size of zero acts as one, a size above the mark count saturates
    function automatic logic [SIZE_W-1:0] f_eff_size(
        input logic [SIZE_W-1:0] raw,
        input int                max_size
    );
        logic [SIZE_W-1:0] eff;
        eff = raw;
        if (raw == '0) begin
            eff = SIZE_W'(1);
        end else if (int'(raw) > max_size) begin
            eff = SIZE_W'(max_size);
        end
        return eff;
    endfunction

endpackage

// File: src/lcpd_if.sv
// Valid/ready channel interfaces of the Lehmer code permutation decoder.
// Depends on lcpd_pkg for the field widths.
interface lcpd_in_if;
    logic                             valid;
    logic                             ready;
    logic [lcpd_pkg::DIGIT_W-1:0]     digit;

    modport source (output valid, output digit, input ready);
    modport sink   (input valid, input digit, output ready);
endinterface

interface lcpd_out_if;
    logic                             valid;
    logic                             ready;
    logic [lcpd_pkg::VALUE_W-1:0]     value;
    logic                             last;
    logic                             error;

    modport source (output valid, output value, output last, output error, input ready);
    modport sink   (input valid, input value, input last, input error, output ready);
endinterface

// File: src/lehmer_code_permutation_decoder.sv
// Lehmer code permutation decoder: one digit word in, one permutation element word out.
// Input register, then select into result register; throughput 1 word/cycle while o_out.ready does not stall it.
// The select and the used-mark update share one cycle, so each digit sees its predecessor.
// Synchronous active-low reset: clears valids, marks and count, size back to 64 clamped to MAX_SIZE.
// A perm_size write restarts the permutation. Depends on lcpd_pkg, lcpd_if, lcpd_select.
module lehmer_code_permutation_decoder #(
    parameter int MAX_SIZE = lcpd_pkg::MAX_SIZE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lcpd_pkg::SIZE_W-1:0]     i_cfg_wdata,
    lcpd_in_if.sink                         i_in,
    lcpd_out_if.source                      o_out
);

    logic                           r_in_valid;
    logic [lcpd_pkg::DIGIT_W-1:0]   r_digit;
    logic                           r_out_valid;
    lcpd_pkg::t_sel                 r_res;
    logic [MAX_SIZE-1:0]            r_marks;
    logic [lcpd_pkg::SIZE_W-1:0]    r_count;
    logic [lcpd_pkg::SIZE_W-1:0]    r_size;

    logic                           adv;
    logic                           step;
    logic [MAX_SIZE-1:0]            pick_oh;
    lcpd_pkg::t_sel                 sel;

    assign adv        = !r_out_valid || o_out.ready;
    assign step       = r_in_valid && adv;
    assign i_in.ready = !r_in_valid || adv;

    lcpd_select #(.MAX_SIZE(MAX_SIZE)) u_select (
        .i_marks   (r_marks),
        .i_size    (r_size),
        .i_count   (r_count),
        .i_digit   (r_digit),
        .o_pick_oh (pick_oh),
        .o_sel     (sel)
    );

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_digit <= i_in.digit;
        end
    end

    // Result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
        if (step) begin
            r_res <= sel;
        end
    end

    // Used marks, count and size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marks <= '0;
            r_count <= '0;
            r_size  <= lcpd_pkg::f_eff_size(lcpd_pkg::SIZE_RESET, MAX_SIZE);
        end else if (i_cfg_we) begin
            r_marks <= '0;
            r_count <= '0;
            r_size  <= lcpd_pkg::f_eff_size(i_cfg_wdata, MAX_SIZE);
        end else if (step && !sel.error) begin
            if (sel.last) begin
                r_marks <= '0;
                r_count <= '0;
            end else begin
                r_marks <= r_marks | pick_oh;
                r_count <= r_count + lcpd_pkg::SIZE_W'(1);
            end
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.value = r_res.value;
    assign o_out.last  = r_res.last;
    assign o_out.error = r_res.error;

`ifndef SYNTHESIS
    a_count_below_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < r_size)
        else $error("emitted count reached permutation size");

    a_marks_match_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_marks) == int'(r_count))
        else $error("used marks disagree with emitted count");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && !sel.error && sel.last) |=> (r_marks == '0 && r_count == '0))
        else $error("marks not cleared after final element");

    a_error_no_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && sel.error && !i_cfg_we) |=> $stable(r_marks) && $stable(r_count))
        else $error("state changed on out-of-range digit");
`endif

endmodule

// File: src/lcpd_select.sv
// Order-statistic select over the used-mark bitmap: finds the (digit+1)-th free value.
// Purely combinational. Depends on lcpd_pkg.
module lcpd_select #(
    parameter int MAX_SIZE = lcpd_pkg::MAX_SIZE_DEF
) (
    input  logic [MAX_SIZE-1:0]              i_marks,
    input  logic [lcpd_pkg::SIZE_W-1:0]      i_size,
    input  logic [lcpd_pkg::SIZE_W-1:0]      i_count,
    input  logic [lcpd_pkg::DIGIT_W-1:0]     i_digit,
    output logic [MAX_SIZE-1:0]              o_pick_oh,
    output lcpd_pkg::t_sel                   o_sel
);

    logic [MAX_SIZE-1:0]            free;
    logic [lcpd_pkg::SIZE_W-1:0]    remaining;
    logic                           err;
    logic [lcpd_pkg::VALUE_W-1:0]   value;

    assign remaining = i_size - i_count;
    assign err       = ({1'b0, i_digit} >= remaining);

    always_comb begin
        for (int i = 0; i < MAX_SIZE; i++) begin
            free[i] = !i_marks[i] && (i < int'(i_size));
        end
    end

    // Each position compares its own count of free values below it with the digit
    always_comb begin
        int cnt;
        cnt = 0;
        for (int i = 0; i < MAX_SIZE; i++) begin
            cnt = $countones(free & ~({MAX_SIZE{1'b1}} << i));
            o_pick_oh[i] = free[i] && !err && (cnt == int'(i_digit));
        end
    end

    always_comb begin
        value = '0;
        for (int i = 0; i < MAX_SIZE; i++) begin
            if (o_pick_oh[i]) begin
                value = value | lcpd_pkg::VALUE_W'(i + 1);
            end
        end
    end

    assign o_sel.error = err;
    assign o_sel.value = err ? '0 : value;
    assign o_sel.last  = !err && ((i_count + lcpd_pkg::SIZE_W'(1)) >= i_size);

endmodule
